### rtl/bld_pkg.sv
// shared types and codes for the bounded list with indexed delete
package bld_pkg;

  // operation codes carried on in_opcode
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_POP_FRONT  = 2'd1;
  localparam logic [1:0] OP_POP_BACK   = 2'd2;
  localparam logic [1:0] OP_DELETE_AT  = 2'd3;

  // status codes carried on out_status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_BADPOS = 2'd3;

  // fixed port field widths
  localparam int POS_W = 5;
  localparam int CNT_OUT_W = 5;
  localparam int DATA_W = 32;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push;        // every cell takes its left neighbor, cell 0 takes the new value
    logic remove;      // cells at or above the hole take their right neighbor
    logic load_pick;   // capture old values, mark the cell that is removed
    logic shift_pick;  // move the pick token one cell toward the front
  } cell_ctrl_t;

endpackage

### rtl/bld_cell.sv
// one storage cell of the list chain with its slot of the pick line
module bld_cell import bld_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 4,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctrl_t             ctrl,
  input  logic [IDX_W-1:0]       del_idx,
  input  logic [VALUE_WIDTH-1:0] left_val,
  input  logic [VALUE_WIDTH-1:0] right_val,
  input  logic                   right_pick_v,
  input  logic [VALUE_WIDTH-1:0] right_pick_d,
  output logic [VALUE_WIDTH-1:0] val,
  output logic                   pick_v,
  output logic [VALUE_WIDTH-1:0] pick_d
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [VALUE_WIDTH-1:0] val_r;
  logic                   pick_v_r;
  logic [VALUE_WIDTH-1:0] pick_d_r;
  logic                   at_or_above;
  logic                   is_hit;

  assign at_or_above = (MY_IDX >= del_idx);
  assign is_hit      = (MY_IDX == del_idx);

  // element storage: shift toward back on push, close the gap on remove
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      val_r <= left_val;
    end else if (ctrl.remove && at_or_above) begin
      val_r <= right_val;
    end
  end

  // pick token valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_v_r <= 1'b0;
    end else if (ctrl.load_pick) begin
      pick_v_r <= is_hit;
    end else if (ctrl.shift_pick) begin
      pick_v_r <= right_pick_v;
    end
  end

  // pick token data
  always_ff @(posedge clk) begin
    if (ctrl.load_pick) begin
      pick_d_r <= val_r;
    end else if (ctrl.shift_pick) begin
      pick_d_r <= right_pick_d;
    end
  end

  assign val    = val_r;
  assign pick_v = pick_v_r;
  assign pick_d = pick_d_r;

endmodule

### rtl/bounded_list_with_indexed_delete_core.sv
// bounded ordered list held in a chain of cells, with front/back pop and indexed delete
// push and failed operations: result loaded into the output register at the input transfer
// removal at 1-based position p: removed value captured at the input transfer, then walks
//   the pick line from its cell to cell 0, one cell per cycle, into the output register
// one item in flight; next input taken once the result sits in an unstalled output register
// synchronous active-low reset empties the list; cell contents are not cleared
module bounded_list_with_indexed_delete_core import bld_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [DATA_W-1:0]   in_push_value,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   out_removed_value,
  output logic [1:0]          out_status,
  output logic [CNT_OUT_W-1:0] out_entries_held
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEEK = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       hold_cnt_r, hold_cnt_nxt;
  logic                   out_valid_r;
  logic [DATA_W-1:0]      out_removed_r;
  logic [1:0]             out_status_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;

  logic                   in_xfer;
  logic                   out_free;
  logic                   consume;
  logic                   direct_load;
  logic [1:0]             dec_status;
  logic                   dec_push;
  logic                   dec_remove;
  logic [IDX_W-1:0]       dec_idx;
  logic [CMP_W-1:0]       pos_c;
  logic [CMP_W-1:0]       fill_c;
  logic [CMP_W-1:0]       direct_cnt_c;
  logic [CMP_W-1:0]       hold_cnt_c;
  logic [VALUE_WIDTH-1:0] push_val;
  logic [DATA_W-1:0]      pick_out;
  cell_ctrl_t             ctrl;

  logic [VALUE_WIDTH-1:0] cell_val    [DEPTH];
  logic                   cell_pick_v [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_pick_d [DEPTH];

  // value width adaptation between the ports and the cells
  generate
    if (VALUE_WIDTH >= DATA_W) begin : g_wide
      assign push_val = VALUE_WIDTH'(in_push_value);
      assign pick_out = cell_pick_d[0][DATA_W-1:0];
    end else begin : g_narrow
      assign push_val = in_push_value[VALUE_WIDTH-1:0];
      assign pick_out = DATA_W'(cell_pick_d[0]);
    end
  endgenerate

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign consume  = (state_r == S_SEEK) && cell_pick_v[0] && out_free;

  // operation decode against the fill count
  assign pos_c  = CMP_W'(in_position);
  assign fill_c = CMP_W'(fill_r);

  always_comb begin
    dec_status = STAT_OK;
    dec_push   = 1'b0;
    dec_remove = 1'b0;
    dec_idx    = '0;
    if (in_opcode == OP_PUSH_FRONT) begin
      if (fill_r == FULL_CNT) begin
        dec_status = STAT_FULL;
      end else begin
        dec_push = 1'b1;
      end
    end else if (fill_r == '0) begin
      dec_status = STAT_EMPTY;
    end else begin
      case (in_opcode)
        OP_POP_FRONT: begin
          dec_remove = 1'b1;
        end
        OP_POP_BACK: begin
          dec_remove = 1'b1;
          dec_idx    = IDX_W'(fill_r - 1'b1);
        end
        OP_DELETE_AT: begin
          if (pos_c == '0 || pos_c > fill_c) begin
            dec_status = STAT_BADPOS;
          end else begin
            dec_remove = 1'b1;
            dec_idx    = IDX_W'(pos_c - 1'b1);
          end
        end
        default: begin
          dec_status = STAT_OK;
        end
      endcase
    end
  end

  // commands to the chain
  always_comb begin
    ctrl.push       = in_xfer && dec_push;
    ctrl.remove     = in_xfer && dec_remove;
    ctrl.load_pick  = in_xfer && dec_remove;
    ctrl.shift_pick = (state_r == S_SEEK) && (!cell_pick_v[0] || out_free);
  end

  // control state and fill count
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    hold_cnt_nxt = hold_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && dec_push) begin
          fill_nxt = fill_r + 1'b1;
        end else if (in_xfer && dec_remove) begin
          fill_nxt     = fill_r - 1'b1;
          hold_cnt_nxt = fill_r - 1'b1;
          state_nxt    = S_SEEK;
        end
      end
      S_SEEK: begin
        if (consume) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_cnt_r <= hold_cnt_nxt;
  end

  // output register
  assign direct_load  = in_xfer && !dec_remove;
  assign direct_cnt_c = CMP_W'(fill_nxt);
  assign hold_cnt_c   = CMP_W'(hold_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (direct_load || consume) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct_load) begin
      out_removed_r <= '0;
      out_status_r  <= dec_status;
      out_cnt_r     <= direct_cnt_c[CNT_OUT_W-1:0];
    end else if (consume) begin
      out_removed_r <= pick_out;
      out_status_r  <= STAT_OK;
      out_cnt_r     <= hold_cnt_c[CNT_OUT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_entries_held  = out_cnt_r;

  // chain of cells, front at index 0
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_val;
      logic [VALUE_WIDTH-1:0] right_val;
      logic                   right_pick_v;
      logic [VALUE_WIDTH-1:0] right_pick_d;

      if (i == 0) begin : g_front
        assign left_val = push_val;
      end else begin : g_inner_l
        assign left_val = cell_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
        assign right_val    = cell_val[i];
        assign right_pick_v = 1'b0;
        assign right_pick_d = '0;
      end else begin : g_inner_r
        assign right_val    = cell_val[i+1];
        assign right_pick_v = cell_pick_v[i+1];
        assign right_pick_d = cell_pick_d[i+1];
      end

      bld_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W),
        .IDX         (i)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .del_idx      (dec_idx),
        .left_val     (left_val),
        .right_val    (right_val),
        .right_pick_v (right_pick_v),
        .right_pick_d (right_pick_d),
        .val          (cell_val[i]),
        .pick_v       (cell_pick_v[i]),
        .pick_d       (cell_pick_d[i])
      );
    end
  endgenerate

endmodule

### rtl/bld_checker.sv
// port-level checks for the bounded list core and their bind
module bld_checker import bld_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DATA_W-1:0]    out_removed_value,
  input logic [1:0]           out_status,
  input logic [CNT_OUT_W-1:0] out_entries_held
);

  // a stalled result transfer keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_removed_value)
      && $stable(out_status) && $stable(out_entries_held))
    else $error("stalled result changed");

  // a rejected push removes nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> (out_removed_value == '0))
    else $error("full status with nonzero removed value");

  // removal from an empty list reports an empty list and nothing removed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |->
      (out_removed_value == '0) && (out_entries_held == '0))
    else $error("empty status with data or nonzero count");

  // a bad position removes nothing and leaves a nonempty list
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_BADPOS) |->
      (out_removed_value == '0) && (out_entries_held != '0))
    else $error("bad position status with nonzero removed value or empty list");

endmodule

bind bounded_list_with_indexed_delete_core bld_checker u_bld_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_removed_value (out_removed_value),
  .out_status        (out_status),
  .out_entries_held  (out_entries_held)
);

### tb/sv/bounded_list_with_indexed_delete_core_tb.sv
// self-checking testbench for the bounded list core with front/back pop and indexed delete
`timescale 1ns / 1ps

module bounded_list_with_indexed_delete_core_tb import bld_pkg::*; ();

  localparam int DEPTH        = 16;
  localparam int VALUE_WIDTH  = 32;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_TAIL   = 60;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [DATA_W-1:0]    push_value;
    logic [POS_W-1:0]     position;
  } list_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]    removed;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] entries;
  } list_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_PUSH_FRONT;
  logic [DATA_W-1:0]    in_push_value = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_removed_value;
  logic [1:0]           out_status;
  logic [CNT_OUT_W-1:0] out_entries_held;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  // predicted list contents, slot 0 is the front
  logic [DATA_W-1:0] list_slots [DEPTH];
  int                list_fill = 0;

  int  gen_fill = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  accepted_count = 0;
  bit  in_taken = 1'b0;
  int  in_gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  bounded_list_with_indexed_delete_core #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_push_value     (in_push_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_entries_held  (out_entries_held)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // apply one operation to the predicted list and return its result
  function automatic list_result_t apply_list_op(input list_op_t op);
    list_result_t res;
    int           idx;
    res.removed = '0;
    res.status  = STAT_OK;
    idx         = -1;
    if (op.opcode == OP_PUSH_FRONT) begin
      if (list_fill >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        for (int i = list_fill; i > 0; i--) list_slots[i] = list_slots[i-1];
        list_slots[0] = op.push_value;
        list_fill++;
      end
    end else if (list_fill == 0) begin
      res.status = STAT_EMPTY;
    end else if (op.opcode == OP_POP_FRONT) begin
      idx = 0;
    end else if (op.opcode == OP_POP_BACK) begin
      idx = list_fill - 1;
    end else if (op.position == 0 || int'(op.position) > list_fill) begin
      res.status = STAT_BADPOS;
    end else begin
      idx = int'(op.position) - 1;
    end
    // close the gap left by the removed element
    if (idx >= 0) begin
      res.removed = list_slots[idx];
      for (int i = idx; i + 1 < list_fill; i++) list_slots[i] = list_slots[i+1];
      list_fill--;
    end
    res.entries = CNT_OUT_W'(list_fill);
    return res;
  endfunction

  // queue one operation and track the fill it leads to, for in-range positions
  function automatic void queue_op(input logic [1:0] opc, input logic [DATA_W-1:0] val,
                                   input logic [POS_W-1:0] pos);
    pending_ops.push_back('{opcode: opc, push_value: val, position: pos});
    if (opc == OP_PUSH_FRONT) begin
      if (gen_fill < DEPTH) gen_fill++;
    end else if (gen_fill != 0 &&
                 (opc != OP_DELETE_AT || (pos != 0 && int'(pos) <= gen_fill))) begin
      gen_fill--;
    end
  endfunction

  // random value with the extremes mixed in
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stimulus_proc
    int          phase;
    int          run_len;
    int          target;
    logic [1:0]  opc;
    logic [POS_W-1:0] pos;

    // empty list: every removing operation
    queue_op(OP_POP_FRONT, 32'h1234_5678, 5'd1);
    queue_op(OP_POP_BACK, 32'h0, 5'd0);
    queue_op(OP_DELETE_AT, 32'hffff_ffff, 5'd1);
    queue_op(OP_DELETE_AT, 32'h0, 5'd31);
    // extreme values
    queue_op(OP_PUSH_FRONT, 32'h7fff_ffff, 5'd31);
    queue_op(OP_PUSH_FRONT, 32'h8000_0000, 5'd0);
    queue_op(OP_PUSH_FRONT, 32'h0, 5'd16);
    queue_op(OP_PUSH_FRONT, 32'hffff_ffff, 5'd1);
    // positions out of range: zero, one past the fill, far above
    queue_op(OP_DELETE_AT, 32'h5555_5555, 5'd0);
    queue_op(OP_DELETE_AT, 32'haaaa_aaaa, 5'd5);
    queue_op(OP_DELETE_AT, 32'h0, 5'd31);
    // delete at the back, then at the front
    queue_op(OP_DELETE_AT, 32'h0, 5'd4);
    queue_op(OP_DELETE_AT, 32'h0, 5'd1);
    queue_op(OP_POP_BACK, 32'h0, 5'd0);
    // single element leaves by the front, then by the back
    queue_op(OP_POP_FRONT, 32'h0, 5'd0);
    queue_op(OP_PUSH_FRONT, 32'hdead_beef, 5'd0);
    queue_op(OP_POP_BACK, 32'h0, 5'd0);
    queue_op(OP_PUSH_FRONT, 32'hcafe_f00d, 5'd0);
    queue_op(OP_DELETE_AT, 32'h0, 5'd1);

    target = pending_ops.size() + RANDOM_ITEMS;
    // first random run fills the list and pushes past full
    repeat (DEPTH + 3) queue_op(OP_PUSH_FRONT, pick_value(), POS_W'($urandom));

    while (pending_ops.size() < target) begin
      phase   = $urandom_range(0, 9);
      run_len = $urandom_range(4, DEPTH + 4);
      if (phase < 3) begin
        // push run
        repeat (run_len) queue_op(OP_PUSH_FRONT, pick_value(), POS_W'($urandom));
      end else if (phase < 6) begin
        // removals, with positions inside the list when it is not empty
        repeat (run_len) begin
          opc = 2'($urandom_range(OP_POP_FRONT, OP_DELETE_AT));
          pos = (gen_fill != 0) ? POS_W'($urandom_range(1, gen_fill))
                                : POS_W'($urandom_range(1, DEPTH));
          queue_op(opc, $urandom, pos);
        end
      end else begin
        // noise: any opcode, any position
        repeat (run_len) queue_op(2'($urandom_range(OP_PUSH_FRONT, OP_DELETE_AT)),
                                  pick_value(), POS_W'($urandom));
      end
    end

    // reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for all transfers and results
    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // sender: present queued items with random gaps
  always @(negedge clk) begin : drive_proc
    list_op_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap_left != 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        in_opcode     <= nxt.opcode;
        in_push_value <= nxt.push_value;
        in_position   <= nxt.position;
        in_valid      <= 1'b1;
        if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
          in_gap_left = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts and one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin : watch_proc
    list_op_t     seen_op;
    list_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        seen_op  = '{opcode: in_opcode, push_value: in_push_value, position: in_position};
        expected_results.push_back(apply_list_op(seen_op));
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_removed_value !== want.removed)
            report_mismatch($sformatf("removed_value got %h want %h",
                                      out_removed_value, want.removed));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_entries_held !== want.entries)
            report_mismatch($sformatf("entries_held got %0d want %0d",
                                      out_entries_held, want.entries));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
